@@ rtl/core/prq_pkg.sv @@
`default_nettype none

package prq_pkg;

    localparam int unsigned RT_W          = 32;
    localparam int unsigned ID_PORT_W     = 6;
    localparam int unsigned BASE_W        = 4;
    localparam int unsigned LVL_PORT_W    = 4;
    localparam int unsigned PEN_W         = 3;
    localparam int unsigned LVL_SUM_W     = 5;
    localparam int unsigned DECAY_SHIFT   = 2;

    localparam logic [PEN_W-1:0] MAX_PENALTY   = 3'd5;
    localparam logic [RT_W-1:0]  QUANTUM_RESET = 32'd13333;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_op;

endpackage

`default_nettype wire

@@ rtl/core/prq_in_if.sv @@
`default_nettype none

interface prq_in_if
    import prq_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [ID_PORT_W-1:0]   task_id;
    logic [BASE_W-1:0]      base_priority;
    logic [RT_W-1:0]        run_time;

    modport source (
        output valid, cmd, task_id, base_priority, run_time,
        input  ready
    );

    modport sink (
        input  valid, cmd, task_id, base_priority, run_time,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/prq_out_if.sv @@
`default_nettype none

interface prq_out_if
    import prq_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [ID_PORT_W-1:0]   popped_id;
    logic                   popped_valid;
    logic [RT_W-1:0]        run_time_out;
    logic [LVL_PORT_W-1:0]  level_used;
    logic                   rejected;

    modport source (
        output valid, popped_id, popped_valid, run_time_out, level_used, rejected,
        input  ready
    );

    modport sink (
        input  valid, popped_id, popped_valid, run_time_out, level_used, rejected,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/prq_cell.sv @@
`default_nettype none

module prq_cell
    import prq_pkg::*;
#(
    parameter int unsigned ID_W  = 6,
    parameter int unsigned LVL_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_op         i_op,
    input  wire logic [ID_W-1:0]  i_new_id,
    input  wire logic [LVL_W-1:0] i_new_lvl,
    input  wire logic             i_prev_valid,
    input  wire logic [ID_W-1:0]  i_prev_id,
    input  wire logic [LVL_W-1:0] i_prev_lvl,
    input  wire logic             i_prev_after,
    input  wire logic             i_next_valid,
    input  wire logic [ID_W-1:0]  i_next_id,
    input  wire logic [LVL_W-1:0] i_next_lvl,
    output logic                  o_valid,
    output logic [ID_W-1:0]       o_id,
    output logic [LVL_W-1:0]      o_lvl,
    output logic                  o_after
);

    logic             r_valid;
    logic [ID_W-1:0]  r_id;
    logic [LVL_W-1:0] r_lvl;
    logic             n_valid;
    logic [ID_W-1:0]  n_id;
    logic [LVL_W-1:0] n_lvl;
    logic             after;

    assign after = !r_valid || (r_lvl > i_new_lvl);

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_lvl   = r_lvl;
        priority if (i_op.pop) begin
            n_valid = i_next_valid;
            n_id    = i_next_id;
            n_lvl   = i_next_lvl;
        end else if (i_op.push && after) begin
            if (i_prev_after) begin
                n_valid = i_prev_valid;
                n_id    = i_prev_id;
                n_lvl   = i_prev_lvl;
            end else begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_lvl   = i_new_lvl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_lvl <= n_lvl;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_lvl   = r_lvl;
    assign o_after = after;

endmodule

`default_nettype wire

@@ rtl/core/prq_penalty.sv @@
`default_nettype none

module prq_penalty
    import prq_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire logic            i_step,
    input  wire logic [RT_W-1:0] i_rt,
    input  wire logic [RT_W-1:0] i_q,
    output logic                 o_done,
    output logic                 o_exceed,
    output logic [PEN_W-1:0]     o_pen
);

    logic [RT_W-1:0]  r_rem;
    logic [PEN_W-1:0] r_pen;
    logic             r_exceed;
    logic [RT_W:0]    diff;
    logic             q_zero;

    assign diff   = {1'b0, r_rem} - {1'b0, i_q};
    assign q_zero = (i_q == '0);
    assign o_done = !r_exceed || q_zero || (r_pen == MAX_PENALTY) || diff[RT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen    <= '0;
            r_exceed <= 1'b0;
        end else if (i_load) begin
            r_pen    <= '0;
            r_exceed <= (i_rt > i_q);
        end else if (i_step && !o_done) begin
            r_pen    <= r_pen + PEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_rt;
        end else if (i_step && !o_done) begin
            r_rem <= diff[RT_W-1:0];
        end
    end

    assign o_exceed = r_exceed;
    assign o_pen    = q_zero ? MAX_PENALTY : r_pen;

endmodule

`default_nettype wire

@@ rtl/core/priority_ready_queue_unit.sv @@
// Steps: the input transfer loads the request and the penalty unit; the penalty unit then
//   takes one quotient step per cycle (capped at five) until it is done and the result slot is free;
//   then the whole cell chain inserts or shifts out and the result is registered.
// A new request is taken only in idle, once the previous one has been applied.
// Reset (synchronous, active low): empties the chain and task flags, quantum set to 13333.
`default_nettype none

module priority_ready_queue_unit
    import prq_pkg::*;
#(
    parameter int unsigned NUM_TASKS  = 64,
    parameter int unsigned NUM_LEVELS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [RT_W-1:0] i_cfg_wdata,
    prq_in_if.sink               i_in,
    prq_out_if.source            o_out
);

    localparam int unsigned ID_W    = $clog2(NUM_TASKS);
    localparam int unsigned LVL_W   = $clog2(NUM_LEVELS);
    localparam int unsigned MAX_LVL = NUM_LEVELS - 1;

    t_state                 r_state;
    t_state                 n_state;
    logic [RT_W-1:0]        r_quantum;
    logic                   r_cmd;
    logic [ID_PORT_W-1:0]   r_id;
    logic [BASE_W-1:0]      r_base;
    logic [RT_W-1:0]        r_rt;
    logic [NUM_TASKS-1:0]   r_queued;

    logic                   r_out_valid;
    logic [ID_PORT_W-1:0]   r_popped_id;
    logic                   r_popped_valid;
    logic [RT_W-1:0]        r_rt_out;
    logic [LVL_PORT_W-1:0]  r_level_used;
    logic                   r_rejected;

    logic                   in_ready;
    logic                   pen_load;
    logic                   pen_step;
    logic                   apply;
    logic                   out_free;
    logic                   pen_done;
    logic                   pen_exceed;
    logic [PEN_W-1:0]       pen;

    logic [ID_W-1:0]        r_idx;
    logic                   out_range;
    logic                   flag_hit;
    logic                   rejected;
    logic                   push_ok;
    logic                   pop_ok;
    logic [LVL_SUM_W-1:0]   lvl_sum;
    logic [LVL_W-1:0]       lvl;
    logic [RT_W-1:0]        rt_out;
    t_cell_op               cell_op;

    logic                   cell_valid [NUM_TASKS];
    logic [ID_W-1:0]        cell_id    [NUM_TASKS];
    logic [LVL_W-1:0]       cell_lvl   [NUM_TASKS];
    logic                   cell_after [NUM_TASKS];
    logic                   head_valid;
    logic [ID_W-1:0]        head_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
        end else if (i_cfg_we) begin
            r_quantum <= i_cfg_wdata;
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_CALC;
            S_CALC:  if (pen_done && out_free) n_state = S_APPLY;
            S_APPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        pen_step = 1'b0;
        apply    = 1'b0;
        unique case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_CALC:  pen_step = 1'b1;
            S_APPLY: apply    = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    assign pen_load   = in_ready && i_in.valid;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pen_load) begin
            r_cmd  <= i_in.cmd;
            r_id   <= i_in.task_id;
            r_base <= i_in.base_priority;
            r_rt   <= i_in.run_time;
        end
    end

    prq_penalty u_penalty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (pen_load),
        .i_step   (pen_step),
        .i_rt     ((i_in.cmd == CMD_POP) ? '0 : i_in.run_time),
        .i_q      (r_quantum),
        .o_done   (pen_done),
        .o_exceed (pen_exceed),
        .o_pen    (pen)
    );

    assign r_idx     = ID_W'(r_id);
    assign out_range = (32'(r_id) >= NUM_TASKS);

    always_comb begin
        flag_hit = out_range ? 1'b0 : r_queued[r_idx];
    end

    assign rejected = out_range || flag_hit;
    assign push_ok  = (r_cmd == CMD_PUSH) && !rejected;
    assign pop_ok   = (r_cmd == CMD_POP) && head_valid;

    assign lvl_sum = LVL_SUM_W'(r_base) + (pen_exceed ? LVL_SUM_W'(pen) : '0);

    always_comb begin
        if (32'(lvl_sum) > MAX_LVL) begin
            lvl = LVL_W'(MAX_LVL);
        end else begin
            lvl = LVL_W'(lvl_sum);
        end
    end

    assign rt_out = pen_exceed ? (r_rt - (r_quantum >> DECAY_SHIFT)) : r_rt;

    assign cell_op.push = apply && push_ok;
    assign cell_op.pop  = apply && pop_ok;

    for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
        logic             prev_valid;
        logic [ID_W-1:0]  prev_id;
        logic [LVL_W-1:0] prev_lvl;
        logic             prev_after;
        logic             next_valid;
        logic [ID_W-1:0]  next_id;
        logic [LVL_W-1:0] next_lvl;

        if (g == 0) begin : g_first
            assign prev_valid = 1'b0;
            assign prev_id    = '0;
            assign prev_lvl   = '0;
            assign prev_after = 1'b0;
        end else begin : g_inner
            assign prev_valid = cell_valid[g-1];
            assign prev_id    = cell_id[g-1];
            assign prev_lvl   = cell_lvl[g-1];
            assign prev_after = cell_after[g-1];
        end

        if (g == NUM_TASKS - 1) begin : g_last
            assign next_valid = 1'b0;
            assign next_id    = '0;
            assign next_lvl   = '0;
        end else begin : g_body
            assign next_valid = cell_valid[g+1];
            assign next_id    = cell_id[g+1];
            assign next_lvl   = cell_lvl[g+1];
        end

        prq_cell #(
            .ID_W  (ID_W),
            .LVL_W (LVL_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (cell_op),
            .i_new_id     (r_idx),
            .i_new_lvl    (lvl),
            .i_prev_valid (prev_valid),
            .i_prev_id    (prev_id),
            .i_prev_lvl   (prev_lvl),
            .i_prev_after (prev_after),
            .i_next_valid (next_valid),
            .i_next_id    (next_id),
            .i_next_lvl   (next_lvl),
            .o_valid      (cell_valid[g]),
            .o_id         (cell_id[g]),
            .o_lvl        (cell_lvl[g]),
            .o_after      (cell_after[g])
        );
    end

    assign head_valid = cell_valid[0];
    assign head_idx   = cell_id[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued <= '0;
        end else if (apply) begin
            if (push_ok) begin
                r_queued[r_idx] <= 1'b1;
            end
            if (pop_ok) begin
                r_queued[head_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (apply) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            if (r_cmd == CMD_POP) begin
                r_popped_id    <= head_valid ? ID_PORT_W'(head_idx) : '0;
                r_popped_valid <= head_valid;
                r_rt_out       <= '0;
                r_level_used   <= '0;
                r_rejected     <= 1'b0;
            end else begin
                r_popped_id    <= '0;
                r_popped_valid <= 1'b0;
                r_rt_out       <= rejected ? r_rt : rt_out;
                r_level_used   <= rejected ? '0 : LVL_PORT_W'(lvl);
                r_rejected     <= rejected;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_id    = r_popped_id;
    assign o_out.popped_valid = r_popped_valid;
    assign o_out.run_time_out = r_rt_out;
    assign o_out.level_used   = r_level_used;
    assign o_out.rejected     = r_rejected;

    a_apply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> !r_out_valid)
        else $error("result overwritten before transfer");

    a_head_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_valid |-> r_queued[head_idx])
        else $error("head task not flagged as queued");

    a_push_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply && push_ok) |=> r_queued[$past(r_idx)])
        else $error("pushed task not flagged");

    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply && pop_ok) |=> !r_queued[$past(head_idx)])
        else $error("popped task still flagged");

    a_chain_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_valid[1] |-> (cell_valid[0] && (cell_lvl[0] <= cell_lvl[1])))
        else $error("cell chain out of order");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;
    import prq_pkg::*;

    localparam int NTASK = 64;
    localparam int NLVL = 16;
    localparam logic [6:0] NO_TASK = 7'd64;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic                  cmd;
        logic [ID_PORT_W-1:0]  task_id;
        logic [BASE_W-1:0]     base_priority;
        logic [RT_W-1:0]       run_time;
    } sched_req_t;

    typedef struct packed {
        logic [ID_PORT_W-1:0]  popped_id;
        logic                  popped_valid;
        logic [RT_W-1:0]       run_time_out;
        logic [LVL_PORT_W-1:0] level_used;
        logic                  rejected;
    } sched_res_t;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [RT_W-1:0] i_cfg_wdata;

    prq_in_if  in_ch ();
    prq_out_if out_ch ();

    priority_ready_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // shadow of the ready queue
    logic [RT_W-1:0]       quantum;
    logic [6:0]            succ [NTASK];
    logic [6:0]            head_task;
    logic [6:0]            tail_at [NLVL];
    logic                  in_queue [NTASK];
    logic [LVL_PORT_W-1:0] linked_level [NTASK];

    sched_req_t pending_reqs [$];
    sched_res_t due_results [$];
    sched_req_t next_req;
    sched_res_t want;

    int errors = 0;
    int cycles = 0;
    int idle_mode = 1;
    int src_gap = 0;
    int sink_stall = 0;
    logic in_xfer = 1'b0;
    int n_push = 0, n_reject = 0, n_pop_hit = 0, n_pop_empty = 0;
    int depth = 0, peak_depth = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic sched_res_t predict_queue_op(sched_req_t r);
        sched_res_t o;
        logic [RT_W-1:0] rt;
        int unsigned lvl;
        int unsigned pen;
        logic [6:0] old;
        logic [6:0] ret;
        int i;
        o = '0;
        if (r.cmd == CMD_PUSH) begin
            rt = r.run_time;
            if (in_queue[r.task_id]) begin
                o.run_time_out = rt;
                o.rejected = 1'b1;
                n_reject++;
            end else begin
                lvl = r.base_priority;
                if (rt > quantum) begin
                    pen = (quantum == 0) ? MAX_PENALTY : rt / quantum;
                    if (pen > MAX_PENALTY)
                        pen = MAX_PENALTY;
                    lvl += pen;
                    rt -= quantum >> DECAY_SHIFT;
                end
                if (lvl > NLVL - 1)
                    lvl = NLVL - 1;
                old = tail_at[lvl];
                if (old == NO_TASK) begin
                    succ[r.task_id] = head_task;
                    head_task = {1'b0, r.task_id};
                end else begin
                    succ[r.task_id] = succ[old[5:0]];
                    succ[old[5:0]] = {1'b0, r.task_id};
                end
                for (i = lvl; i < NLVL && tail_at[i] == old; i++)
                    tail_at[i] = {1'b0, r.task_id};
                in_queue[r.task_id] = 1'b1;
                linked_level[r.task_id] = LVL_PORT_W'(lvl);
                o.run_time_out = rt;
                o.level_used = LVL_PORT_W'(lvl);
                n_push++;
                depth++;
                if (depth > peak_depth)
                    peak_depth = depth;
            end
        end else begin
            ret = head_task;
            if (ret == NO_TASK) begin
                n_pop_empty++;
            end else begin
                head_task = succ[ret[5:0]];
                lvl = linked_level[ret[5:0]];
                if (tail_at[lvl] == ret) begin
                    tail_at[lvl] = (lvl == 0) ? NO_TASK : tail_at[lvl - 1];
                    for (i = lvl + 1; i < NLVL && tail_at[i] == ret; i++)
                        tail_at[i] = tail_at[i - 1];
                end
                in_queue[ret[5:0]] = 1'b0;
                o.popped_id = ret[5:0];
                o.popped_valid = 1'b1;
                n_pop_hit++;
                depth--;
            end
        end
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0)
            return 0;
        if (idle_mode == 1) begin
            if (r < 70) return 0;
            if (r < 93) return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [RT_W-1:0] pick_run_time(logic [RT_W-1:0] q);
        longint unsigned qq;
        longint unsigned v;
        qq = q;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = $urandom;
            2: v = 64'hFFFF_FFFF;
            3: v = qq;
            4: v = qq + 1;
            5, 6: v = qq * $urandom_range(1, 7) + ($urandom % (qq + 1));
            7: v = (qq == 0) ? 0 : $urandom % qq;
            default: v = $urandom_range(0, 255);
        endcase
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[RT_W-1:0];
    endfunction

    task automatic add_push(int id, int base, logic [RT_W-1:0] rt);
        sched_req_t r;
        r.cmd = CMD_PUSH;
        r.task_id = ID_PORT_W'(id);
        r.base_priority = BASE_W'(base);
        r.run_time = rt;
        pending_reqs.push_back(r);
    endtask

    task automatic add_pop();
        sched_req_t r;
        r.cmd = CMD_POP;
        r.task_id = ID_PORT_W'($urandom);
        r.base_priority = BASE_W'($urandom);
        r.run_time = $urandom;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (!(pending_reqs.size() == 0 && due_results.size() == 0 && !in_ch.valid))
            @(posedge i_clk);
    endtask

    task automatic set_quantum(logic [RT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic plan_phase(int count, int push_pct);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < push_pct) begin
                add_push($urandom_range(0, NTASK - 1),
                         ($urandom_range(0, 3) == 0) ? 15 * $urandom_range(0, 1)
                                                     : $urandom_range(0, 15),
                         pick_run_time(quantum));
            end else begin
                add_pop();
            end
        end
    endtask

    task automatic show_diff(string field, longint unsigned exp_v, longint unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, exp_v, got_v);
            errors++;
        end
    endtask

    // driver: present the next request, hold it until the transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_xfer) begin
            in_ch.valid <= 1'b1;
        end else if (src_gap > 0) begin
            in_ch.valid <= 1'b0;
            src_gap = src_gap - 1;
        end else if (pending_reqs.size() > 0) begin
            next_req = pending_reqs.pop_front();
            in_ch.cmd <= next_req.cmd;
            in_ch.task_id <= next_req.task_id;
            in_ch.base_priority <= next_req.base_priority;
            in_ch.run_time <= next_req.run_time;
            in_ch.valid <= 1'b1;
            src_gap = pick_gap();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            out_ch.ready <= 1'b0;
            sink_stall = sink_stall - 1;
        end else begin
            out_ch.ready <= 1'b1;
            sink_stall = pick_gap();
        end
    end

    // monitor: predict on input transfers, check on output transfers
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_we)
                quantum = i_cfg_wdata;
            in_xfer <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                due_results.push_back(predict_queue_op({in_ch.cmd, in_ch.task_id,
                                                        in_ch.base_priority,
                                                        in_ch.run_time}));
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got id %0h rt %0h",
                             $time, out_ch.popped_id, out_ch.run_time_out);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    show_diff("popped_id", want.popped_id, out_ch.popped_id);
                    show_diff("popped_valid", want.popped_valid, out_ch.popped_valid);
                    show_diff("run_time_out", want.run_time_out, out_ch.run_time_out);
                    show_diff("level_used", want.level_used, out_ch.level_used);
                    show_diff("rejected", want.rejected, out_ch.rejected);
                end
            end
        end
    end

    initial begin : stimulus
        int p;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_PUSH;
        in_ch.task_id = '0;
        in_ch.base_priority = '0;
        in_ch.run_time = '0;
        out_ch.ready = 1'b0;
        quantum = QUANTUM_RESET;
        head_task = NO_TASK;
        for (p = 0; p < NTASK; p++) begin
            succ[p] = '0;
            in_queue[p] = 1'b0;
            linked_level[p] = '0;
        end
        for (p = 0; p < NLVL; p++)
            tail_at[p] = NO_TASK;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset quantum: empty pop, extremes, duplicate, penalty edges, FIFO order
        add_pop();
        add_push(0, 0, 0);
        add_push(63, 15, 32'hFFFF_FFFF);
        add_push(0, 3, 100);
        add_push(5, 0, 13333);
        add_push(6, 0, 13334);
        add_push(7, 3, 66665);
        add_push(8, 2, 200000);
        add_push(9, 12, 40000);
        add_push(42, 0, 5);
        add_push(21, 1, 0);
        repeat (10) add_pop();
        drain();

        // zero quantum: full penalty, no decay
        set_quantum('0);
        add_push(1, 2, 1);
        add_push(2, 15, 0);
        add_push(3, 0, 32'hFFFF_FFFF);
        repeat (3) add_pop();
        drain();

        for (p = 0; p < 7; p++) begin
            case (p)
                0: set_quantum(QUANTUM_RESET);
                1: set_quantum(32'd4);
                2: set_quantum(32'hFFFF_FFFF);
                3: set_quantum('0);
                4: set_quantum($urandom_range(4, 200000));
                5: set_quantum($urandom);
                default: set_quantum(32'd1);
            endcase
            idle_mode = p % 3;
            @(negedge i_clk);
            case (p)
                0: plan_phase(150, 75);
                1: plan_phase(120, 50);
                2: plan_phase(120, 40);
                3: plan_phase(100, 60);
                4: plan_phase(130, 55);
                5: plan_phase(100, 30);
                default: plan_phase(130, 55);
            endcase
            drain();
        end

        repeat (16) @(posedge i_clk);
        $display("Covered %0d pushes (%0d refused), %0d pops with a task, %0d empty pops,",
                 n_push, n_reject, n_pop_hit, n_pop_empty);
        $display("queue depth up to %0d, quantum at zero, minimum, maximum and random.",
                 peak_depth);
        if (due_results.size() != 0)
            $display("%0t: %0d results still outstanding", $time, due_results.size());
        if (errors == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
